// File: hw/rtl/hbp_pkg.sv
// shared types and constants for the huffman symbol bit packer
// no dependencies; imported by every module of the block
package hbp_pkg;

	localparam int MAX_CODE_BITS = 32;
	localparam int SYMBOL_COUNT  = 256;
	localparam int SYM_AW        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int BYTE_BITS     = 8;
	localparam int MAX_BYTES     = 4;
	localparam logic [5:0] CODE_LIMIT = (MAX_CODE_BITS < 32) ? 6'(MAX_CODE_BITS) : 6'd32;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  symbol;
		logic [5:0]  code_length;
		logic [31:0] code_bits;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic [2:0] pad_bits;
		logic       last;
	} result_t;

	// one looked-up item handed to the packer
	typedef struct packed {
		logic        encode;
		logic        flush;
		logic [5:0]  len;
		logic [31:0] code;
	} pack_req_t;

endpackage

// File: hw/rtl/huffman_symbol_bit_packer_unit.sv
// huffman symbol bit packer: table lookup register, then accumulate and emit
// lookup register, then packer word register; one result per cycle unless stalled
// if not stalled, one item per cycle when at most one byte, else one per byte
// an encode makes up to four results, set by the single-byte result port
// reset: accumulator empty, every table entry absent (per-entry valid bits), no sweep
// depends on hbp_pkg, hbp_code_store, hbp_packer
module huffman_symbol_bit_packer_unit
	import hbp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic              vld_s1;
	logic              encode_s1;
	logic              flush_s1;
	logic              accept;
	logic              pk_ready;
	logic              sym_ok;
	logic [5:0]        len_sat;
	logic [5:0]        rd_len;
	logic [31:0]       rd_code;
	pack_req_t         req;

	assign sym_ok     = {1'b0, item.symbol} < 9'(SYMBOL_COUNT);
	assign len_sat    = (item.code_length > CODE_LIMIT) ? CODE_LIMIT : item.code_length;
	assign item_stall = vld_s1 && !pk_ready;
	assign accept     = item_valid && !item_stall;

	hbp_code_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && item.operation == OP_LOAD && sym_ok),
		.wr_addr (item.symbol[SYM_AW-1:0]),
		.wr_len  (len_sat),
		.wr_code (item.code_bits),
		.rd_en   (accept),
		.rd_addr (item.symbol[SYM_AW-1:0]),
		.rd_len  (rd_len),
		.rd_code (rd_code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			encode_s1 <= 1'b0;
			flush_s1  <= 1'b0;
		end else if (accept) begin
			vld_s1    <= 1'b1;
			encode_s1 <= item.operation == OP_ENCODE && sym_ok;
			flush_s1  <= item.operation == OP_FLUSH;
		end else if (pk_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_comb begin
		req.encode = encode_s1;
		req.flush  = flush_s1;
		req.len    = rd_len;
		req.code   = rd_code;
	end

	hbp_packer u_packer (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (vld_s1),
		.req          (req),
		.req_ready    (pk_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: hw/rtl/hbp_code_store.sv
// code table storage: length and code memories with per-entry valid bits
// depends on hbp_pkg
module hbp_code_store
	import hbp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [SYM_AW-1:0] wr_addr,
	input  logic [5:0]        wr_len,
	input  logic [31:0]       wr_code,
	input  logic              rd_en,
	input  logic [SYM_AW-1:0] rd_addr,
	output logic [5:0]        rd_len,
	output logic [31:0]       rd_code
);

	logic [5:0]              len_mem [SYMBOL_COUNT];
	logic [31:0]             code_mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] valid_q;
	logic [5:0]              len_s1;
	logic [31:0]             code_s1;
	logic                    hit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_s1  <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_s1 <= valid_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			len_mem[wr_addr]  <= wr_len;
			code_mem[wr_addr] <= wr_code;
		end
		if (rd_en) begin
			len_s1  <= len_mem[rd_addr];
			code_s1 <= code_mem[rd_addr];
		end
	end

	// never-loaded entries read as absent
	assign rd_len  = hit_s1 ? len_s1 : 6'd0;
	assign rd_code = code_s1;

endmodule

// File: hw/rtl/hbp_packer.sv
// bit accumulator and byte emit buffer, one byte per result transfer
// depends on hbp_pkg
module hbp_packer
	import hbp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  pack_req_t req,
	output logic      req_ready,
	output logic      result_valid,
	input  logic      result_stall,
	output result_t   result
);

	logic [6:0]  acc_q;
	logic [2:0]  cnt_q;
	logic [31:0] word_q;
	logic [2:0]  rem_q;
	logic        flush_q;
	logic        fvalid_q;
	logic [2:0]  fpad_q;

	logic [32:0] len_mask;
	logic [31:0] code_m;
	logic [38:0] joined;
	logic [5:0]  total;
	logic [5:0]  align_sh;
	logic [39:0] aligned;
	logic [6:0]  acc_mask;
	logic [2:0]  fpad;
	logic [7:0]  fbyte;
	logic        take;
	logic        out_xfer;

	always_comb begin
		len_mask = (33'd1 << req.len) - 33'd1;
		code_m   = req.code & len_mask[31:0];
		joined   = ({32'd0, acc_q} << req.len) | {7'd0, code_m};
		total    = {3'd0, cnt_q} + req.len;
		align_sh = 6'd40 - total;
		aligned  = {1'b0, joined} << align_sh;
		acc_mask = 7'((8'd1 << total[2:0]) - 8'd1);
		fpad     = 3'(4'd8 - {1'b0, cnt_q});
		fbyte    = {1'b0, acc_q} << fpad;
	end

	assign out_xfer     = result_valid && !result_stall;
	assign req_ready    = (rem_q == 3'd0) || ((rem_q == 3'd1) && !result_stall);
	assign take         = req_valid && req_ready;
	assign result_valid = rem_q != 3'd0;

	always_comb begin
		result.out_byte   = word_q[31:24];
		result.byte_valid = flush_q ? fvalid_q : 1'b1;
		result.pad_bits   = flush_q ? fpad_q : 3'd0;
		result.last       = rem_q == 3'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			rem_q <= '0;
		end else begin
			if (out_xfer) begin
				rem_q <= rem_q - 3'd1;
			end
			if (take && req.encode) begin
				acc_q <= joined[6:0] & acc_mask;
				cnt_q <= total[2:0];
				rem_q <= total[5:3];
			end else if (take && req.flush) begin
				acc_q <= '0;
				cnt_q <= '0;
				rem_q <= 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_xfer) begin
			word_q <= {word_q[23:0], 8'd0};
		end
		if (take && req.encode) begin
			word_q  <= aligned[39:8];
			flush_q <= 1'b0;
		end else if (take && req.flush) begin
			// empty accumulator gives an all-zero result
			word_q   <= {fbyte, 24'd0};
			flush_q  <= 1'b1;
			fvalid_q <= cnt_q != 3'd0;
			fpad_q   <= (cnt_q != 3'd0) ? fpad : 3'd0;
		end
	end

endmodule

// File: hw/rtl/hbp_checker.sv
// port-level checks on the result channel of the bit packer
// depends on hbp_pkg; bound to huffman_symbol_bit_packer_unit below
module hbp_checker
	import hbp_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// bytes of one item go out back to back
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !result.last |=> result_valid)
		else $error("gap inside a result burst");

	// padding only on a final flush byte
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.pad_bits != 3'd0 |-> result.last && result.byte_valid)
		else $error("pad bits on a non-final or empty result");

	// an empty flush result carries nothing
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.byte_valid |->
			result.last && result.out_byte == 8'd0 && result.pad_bits == 3'd0)
		else $error("empty result carries data");

endmodule

bind huffman_symbol_bit_packer_unit hbp_checker u_hbp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
